FILE: hw/rtl/dbls_pkg.sv
// Shared types, constants, coefficient table and operation sequence of the ladder step.
`timescale 1ns / 1ps
`default_nettype none
package dbls_pkg;

  localparam int N         = 8;
  localparam int LOG2N     = 3;
  localparam int ELEMS     = N * N;
  localparam int AW        = 2 * LOG2N;
  localparam int CW        = 3 * LOG2N;
  localparam int SAMPLE_W  = 18;
  localparam int FRAC_W    = 8;
  localparam int COEF_W    = 9;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 32;
  localparam int ACC_FRAC  = 22;
  localparam int ALIGN_SH  = ACC_FRAC - 2 * FRAC_W;
  localparam int FLOOR_SH  = ACC_FRAC - FRAC_W;
  localparam int NUM_OPS   = 10;
  localparam int OP_W      = 4;
  localparam int TDATA_W   = 40;
  localparam int NUM_ST    = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic REG_DIRECTION = 1'b0;

  typedef enum logic [2:0] {ST_P, ST_S, ST_A, ST_B, ST_T} store_e;
  typedef enum logic {OP_MM, OP_EW} op_kind_e;

  typedef struct packed {
    op_kind_e kind;
    logic     rom_left;
    logic     rom_tr;
    store_e   x;
    store_e   y;
    store_e   z;
    logic     use_z;
    logic     neg;
    store_e   dst;
  } op_t;

  localparam logic signed [COEF_W-1:0] COEF_ROM [ELEMS] = '{
      9'sd90,   9'sd90,   9'sd90,   9'sd90,   9'sd90,   9'sd90,   9'sd90,   9'sd90,
     9'sd125,  9'sd106,   9'sd71,   9'sd24,  -9'sd25,  -9'sd72, -9'sd107, -9'sd126,
     9'sd118,   9'sd48,  -9'sd49, -9'sd119, -9'sd119,  -9'sd49,   9'sd48,  9'sd118,
     9'sd106,  -9'sd25, -9'sd126,  -9'sd72,   9'sd71,  9'sd125,   9'sd24, -9'sd107,
      9'sd90,  -9'sd91,  -9'sd91,   9'sd90,   9'sd90,  -9'sd91,  -9'sd91,   9'sd90,
      9'sd71, -9'sd126,   9'sd24,  9'sd106, -9'sd107,  -9'sd25,  9'sd125,  -9'sd72,
      9'sd48, -9'sd119,  9'sd118,  -9'sd49,  -9'sd49,  9'sd118, -9'sd119,   9'sd48,
      9'sd24,  -9'sd72,  9'sd106, -9'sd126,  9'sd125, -9'sd107,   9'sd71,  -9'sd25
  };

  function automatic logic signed [COEF_W-1:0] coef(logic [LOG2N-1:0] row,
                                                     logic [LOG2N-1:0] col);
    return COEF_ROM[{row, col}];
  endfunction

  function automatic op_t mm(logic rl, logic tr, store_e src, store_e dst);
    op_t o;
    o = '{kind: OP_MM, rom_left: rl, rom_tr: tr, x: src, y: ST_P, z: ST_P,
          use_z: 1'b0, neg: 1'b0, dst: dst};
    return o;
  endfunction

  function automatic op_t ew(store_e x, store_e y, store_e z, logic uz, logic ng,
                             store_e dst);
    op_t o;
    o = '{kind: OP_EW, rom_left: 1'b0, rom_tr: 1'b0, x: x, y: y, z: z,
          use_z: uz, neg: ng, dst: dst};
    return o;
  endfunction

  function automatic op_t op_get(logic inv, logic [OP_W-1:0] idx);
    op_t o;
    case ({inv, idx})
      5'h00:   o = mm(1'b1, 1'b1, ST_S, ST_T);
      5'h01:   o = mm(1'b0, 1'b0, ST_T, ST_A);
      5'h02:   o = ew(ST_P, ST_A, ST_P, 1'b0, 1'b1, ST_A);
      5'h03:   o = mm(1'b1, 1'b0, ST_A, ST_T);
      5'h04:   o = mm(1'b0, 1'b1, ST_T, ST_B);
      5'h05:   o = ew(ST_S, ST_B, ST_A, 1'b1, 1'b0, ST_B);
      5'h06:   o = ew(ST_A, ST_B, ST_P, 1'b0, 1'b0, ST_P);
      5'h07:   o = mm(1'b1, 1'b1, ST_P, ST_T);
      5'h08:   o = mm(1'b0, 1'b0, ST_T, ST_A);
      5'h09:   o = ew(ST_B, ST_A, ST_P, 1'b1, 1'b0, ST_S);
      5'h10:   o = mm(1'b1, 1'b1, ST_P, ST_T);
      5'h11:   o = mm(1'b0, 1'b0, ST_T, ST_A);
      5'h12:   o = ew(ST_S, ST_A, ST_P, 1'b1, 1'b1, ST_B);
      5'h13:   o = ew(ST_P, ST_B, ST_P, 1'b0, 1'b1, ST_A);
      5'h14:   o = mm(1'b1, 1'b0, ST_A, ST_T);
      5'h15:   o = mm(1'b0, 1'b1, ST_T, ST_P);
      5'h16:   o = ew(ST_B, ST_P, ST_A, 1'b1, 1'b1, ST_S);
      5'h17:   o = mm(1'b1, 1'b1, ST_S, ST_T);
      5'h18:   o = mm(1'b0, 1'b0, ST_T, ST_P);
      5'h19:   o = ew(ST_A, ST_P, ST_P, 1'b0, 1'b0, ST_P);
      default: o = ew(ST_P, ST_P, ST_P, 1'b0, 1'b0, ST_P);
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dbls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dbls_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/dct_block_ladder_step_top.sv
// Top level of the DCT block ladder step: loader, shared MAC sequencer and output stage.
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | tvalid / tready            | tdata: primary, state sample pair
//  m_axis    | out | tvalid / tready / tlast    | tdata: primary, state result pair
//  apb       | in  | psel / penable / pready    | direction register at address 0
//
// Load takes one pair per cycle; 64 pairs make a block.
// The ladder then runs six 512-step matrix products on one shared 18x9 multiplier
// plus four 64-step element passes, each followed by a pipeline drain.
// Each result pair then passes through the read, load and wait states, and is held in wait while m_axis stalls.
// Reset returns the block to load with an empty block; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dct_block_ladder_step_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [17:0] primary_sample, [35:18] state_sample, [39:36] zero
  input  wire logic [dbls_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [17:0] primary_result, [35:18] state_result, [39:36] zero
  output logic      [dbls_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [dbls_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [dbls_pkg::PDATA_W-1:0]  pwdata_i,
  output logic      [dbls_pkg::PDATA_W-1:0]  prdata_o,
  output logic                               pready_o
);
  import dbls_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_RUN, S_DRAIN, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               cnt_q;
  logic [OP_W-1:0]             op_q;
  logic                        dir_q;
  logic                        run_dir_q;
  logic                        v1_q, first1_q, last1_q;
  logic                        v2_q, first2_q, last2_q;
  logic [AW-1:0]               waddr1_q, waddr2_q;
  logic signed [COEF_W-1:0]    coef1_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic [ACC_W-1:0]            acc_q;
  logic                        m_tvalid_q, m_tlast_q;
  logic [TDATA_W-1:0]          m_tdata_q;

  op_t                         op;
  logic [LOG2N-1:0]            ci, cj, ck;
  logic [AW-1:0]               mm_addr, raddr, waddr;
  logic [LOG2N-1:0]            crow, ccol;
  logic [SAMPLE_W-1:0]         rd [NUM_ST];
  logic [SAMPLE_W-1:0]         wdata [NUM_ST];
  logic                        we [NUM_ST];
  logic [SAMPLE_W-1:0]         ew_x, ew_d, ew_res, mm_res;
  logic [ACC_W-1:0]            acc_sum, aligned;
  logic                        in_acc, load_we, ew_we, mm_we, last_issue;

  assign op      = op_get(run_dir_q, op_q);
  assign ci      = cnt_q[3*LOG2N-1:2*LOG2N];
  assign cj      = cnt_q[2*LOG2N-1:LOG2N];
  assign ck      = cnt_q[LOG2N-1:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign load_we = in_acc;
  assign ew_we   = v1_q && (op.kind == OP_EW);
  assign mm_we   = v2_q && last2_q;

  always_comb begin
    if (op.rom_left) begin
      mm_addr = {ck, cj};
      crow    = op.rom_tr ? ck : ci;
      ccol    = op.rom_tr ? ci : ck;
    end else begin
      mm_addr = {ci, ck};
      crow    = op.rom_tr ? cj : ck;
      ccol    = op.rom_tr ? ck : cj;
    end
  end

  assign raddr = (state_q == S_RUN && op.kind == OP_MM) ? mm_addr : cnt_q[AW-1:0];
  assign last_issue = (op.kind == OP_MM) ? (&cnt_q) : (&cnt_q[AW-1:0]);

  assign ew_x   = rd[op.x];
  assign ew_d   = rd[op.y] - (op.use_z ? rd[op.z] : '0);
  assign ew_res = op.neg ? (ew_x - ew_d) : (ew_x + ew_d);

  assign aligned = ACC_W'(signed'(prod_q)) << ALIGN_SH;
  assign acc_sum = (first2_q ? '0 : acc_q) + aligned;
  assign mm_res  = acc_sum[FLOOR_SH +: SAMPLE_W];

  assign waddr = (state_q == S_LOAD) ? cnt_q[AW-1:0] : (ew_we ? waddr1_q : waddr2_q);

  always_comb begin
    for (int g = 0; g < NUM_ST; g++) begin
      we[g] = (load_we && (store_e'(3'(g)) == ST_P || store_e'(3'(g)) == ST_S)) ||
              ((ew_we || mm_we) && op.dst == store_e'(3'(g)));
      if (state_q == S_LOAD) begin
        wdata[g] = (store_e'(3'(g)) == ST_S) ? s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W]
                                             : s_axis_tdata_i[SAMPLE_W-1:0];
      end else begin
        wdata[g] = ew_we ? ew_res : mm_res;
      end
    end
  end

  for (genvar g = 0; g < NUM_ST; g++) begin : g_store
    dbls_ram #(.WIDTH(SAMPLE_W), .DEPTH(ELEMS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (waddr),
      .wdata_i (wdata[g]),
      .raddr_i (raddr),
      .rdata_o (rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      op_q       <= '0;
      dir_q      <= 1'b0;
      run_dir_q  <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
      m_tlast_q  <= 1'b0;
    end else begin
      if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_DIRECTION) begin
        dir_q <= pwdata_i[0];
      end
      v1_q <= (state_q == S_RUN);
      v2_q <= v1_q && (op.kind == OP_MM);
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (&cnt_q[AW-1:0]) begin
              cnt_q     <= '0;
              op_q      <= '0;
              run_dir_q <= dir_q;
              state_q   <= S_RUN;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        S_RUN: begin
          if (last_issue) begin
            cnt_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) begin
            if (op_q == OP_W'(NUM_OPS - 1)) begin
              state_q <= S_OUT_RD;
            end else begin
              op_q    <= op_q + OP_W'(1);
              state_q <= S_RUN;
            end
          end
        end
        S_OUT_RD: begin
          state_q <= S_OUT_LD;
        end
        S_OUT_LD: begin
          m_tvalid_q <= 1'b1;
          m_tlast_q  <= &cnt_q[AW-1:0];
          state_q    <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (m_axis_tready_i) begin
            m_tvalid_q <= 1'b0;
            if (m_tlast_q) begin
              cnt_q   <= '0;
              state_q <= S_LOAD;
            end else begin
              cnt_q   <= cnt_q + CW'(1);
              state_q <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q <= (ck == '0);
    last1_q  <= (&ck);
    waddr1_q <= (op.kind == OP_MM) ? {ci, cj} : cnt_q[AW-1:0];
    coef1_q  <= coef(crow, ccol);
    first2_q <= first1_q;
    last2_q  <= last1_q;
    waddr2_q <= waddr1_q;
    prod_q   <= signed'(rd[op.x]) * coef1_q;
    if (v2_q) begin
      acc_q <= acc_sum;
    end
    if (state_q == S_OUT_LD) begin
      m_tdata_q <= {(TDATA_W - 2 * SAMPLE_W)'(0), rd[ST_S], rd[ST_P]};
    end
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i[2] == REG_DIRECTION) ? {(PDATA_W - 1)'(0), dir_q} : '0;
endmodule
`default_nettype wire

FILE: hw/rtl/dct_block_ladder_step_chk.sv
// Port-level checker for the ladder step, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dct_block_ladder_step_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic       pready_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("load and result phases overlap");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("block end did not return to load");

  a_in_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("result appeared right after a load transaction");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");
endmodule

bind dct_block_ladder_step_top dct_block_ladder_step_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .pready_o        (pready_o)
);
`default_nettype wire
